// ===== rtl/itf_pkg.sv =====
package itf_pkg;

  // Digit store: 22 nibbles, enough for a 64-bit value in octal.
  localparam int NumDigits = 22;
  localparam int NumDec    = 20;
  localparam int NumHex    = 16;
  localparam int DigW      = 4 * NumDigits;
  localparam int DcntW     = $clog2(NumDigits + 1);
  localparam int MaxItems  = 62;
  localparam int QDepth    = 2;

  localparam logic [2:0] CONV_SDEC = 3'd0;
  localparam logic [2:0] CONV_UDEC = 3'd1;
  localparam logic [2:0] CONV_OCT  = 3'd2;
  localparam logic [2:0] CONV_HEXL = 3'd3;
  localparam logic [2:0] CONV_HEXU = 3'd4;

  localparam logic [1:0] SMODE_MINUS = 2'd0;
  localparam logic [1:0] SMODE_PLUS  = 2'd1;
  localparam logic [1:0] SMODE_SPACE = 2'd2;
  localparam logic [1:0] SMODE_RSVD  = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_OVF   = 2'd2
  } kind_t;

  // One planned conversion, handed from the front to the back.
  typedef struct packed {
    kind_t             kind;
    logic              has_sign;
    logic [7:0]        sign_char;
    logic              hex_prefix;
    logic              upper;
    logic [5:0]        zeros;
    logic [DigW-1:0]   digits;
    logic [5:0]        total;
  } plan_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_ch;
    base_ch = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0000, d};
    end
    return base_ch + {4'b0000, d} - 8'd10;
  endfunction

endpackage

// ===== rtl/integer_to_text_formatter_unit.sv =====
// Channel   Handshake          Word
// -------   ----------------   -------------------------------------------------
// input     start / busy       value, conversion, sign_mode, zero_pad,
//                              alternate, min_digits, pad_width
// result    strobe             character, last, empty_res, overflow
//
// The front takes a word when start is high and busy is low. Busy then covers the
// shift-and-add-3 conversion for decimal (none for octal and hex), a scan that strips
// leading zeros, keeping at least one, and the planning and queueing of the text; an
// empty text skips the conversion and the scan.
// The back sends one character per cycle from a two-word queue, returning to idle between
// texts; the receiver cannot stall, so the front waits only when the queue is full.
// Reset clears both sequencers and the queue.
module integer_to_text_formatter_unit #(
  parameter int LENGTH_LIMIT = 60
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [2:0]  conversion,
  input  logic [1:0]  sign_mode,
  input  logic        zero_pad,
  input  logic        alternate,
  input  logic [6:0]  min_digits,
  input  logic [6:0]  pad_width,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last,
  output logic        empty_res,
  output logic        overflow
);
  import itf_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_nempty;
  plan_t q_wdata;
  plan_t q_rdata;

  itf_front #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .conversion (conversion),
    .sign_mode  (sign_mode),
    .zero_pad   (zero_pad),
    .alternate  (alternate),
    .min_digits (min_digits),
    .pad_width  (pad_width),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  itf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .nempty(q_nempty)
  );

  itf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_nempty (q_nempty),
    .q_pop    (q_pop),
    .q_data   (q_rdata),
    .strobe   (strobe),
    .character(character),
    .last     (last),
    .empty_res(empty_res),
    .overflow (overflow)
  );

  a_flag_exclusive: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(empty_res && overflow))
    else $error("empty and overflow marked together");

  a_flag_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (empty_res || overflow)) |-> (last && (character == CH_NONE)))
    else $error("flag word is not a lone final word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("front did not go busy after taking a word");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into a full queue");

endmodule

// ===== rtl/itf_front.sv =====
module itf_front #(
  parameter int LENGTH_LIMIT = 60
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [63:0]   value,
  input  logic [2:0]    conversion,
  input  logic [1:0]    sign_mode,
  input  logic          zero_pad,
  input  logic          alternate,
  input  logic [6:0]    min_digits,
  input  logic [6:0]    pad_width,
  input  logic          q_full,
  output logic          q_push,
  output itf_pkg::plan_t q_data
);
  import itf_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_CONV = 5'b00010,
    F_SCAN = 5'b00100,
    F_PLAN = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  localparam logic signed [8:0] Limit9 = 9'(LENGTH_LIMIT);
  localparam logic signed [8:0] Max9   = 9'(MaxItems);

  fstate_t          state;
  logic [63:0]      mag;
  logic [DigW-1:0]  digs;
  logic [5:0]       bitcnt;
  logic [DcntW-1:0] dcnt;
  logic             is_empty;
  logic             has_sign;
  logic [7:0]       sign_char;
  logic             hex_prefix;
  logic             upper;
  logic             alt_zero;
  logic signed [8:0] prec;
  plan_t            entry;

  // Decode of the incoming word.
  logic [2:0]       conv_n;
  logic [1:0]       smode_n;
  logic             a_neg, a_zero, a_dec, a_oct, a_hexalt, a_sign, a_empty, a_az;
  logic [63:0]      a_mag;
  logic [7:0]       a_sign_char;
  logic signed [8:0] a_prec;
  logic [65:0]      mag_ext;
  logic [DigW-1:0]  oct_digs;

  always_comb begin
    conv_n   = (conversion > CONV_HEXU) ? CONV_UDEC : conversion;
    a_dec    = (conv_n == CONV_SDEC) || (conv_n == CONV_UDEC);
    a_oct    = (conv_n == CONV_OCT);
    smode_n  = ((conv_n != CONV_SDEC) || (sign_mode == SMODE_RSVD)) ? SMODE_MINUS : sign_mode;
    a_neg    = (conv_n == CONV_SDEC) && value[63];
    a_mag    = a_neg ? (64'd0 - value) : value;
    a_zero   = (value == 64'd0);
    a_sign   = a_neg || (smode_n != SMODE_MINUS);
    a_hexalt = alternate && !a_dec && !a_oct;
    a_az     = alternate && a_oct && !a_zero;
    a_empty  = a_zero && (min_digits == 7'd0) && !(alternate && a_oct);
    if (a_neg) begin
      a_sign_char = CH_MINUS;
    end else if (smode_n == SMODE_PLUS) begin
      a_sign_char = CH_PLUS;
    end else begin
      a_sign_char = CH_SPACE;
    end
    if (zero_pad) begin
      a_prec = signed'({2'b00, pad_width}) - (a_sign ? 9'sd1 : 9'sd0)
               - (a_hexalt ? 9'sd2 : 9'sd0);
    end else begin
      a_prec = signed'({2'b00, min_digits});
    end
    mag_ext = {2'b00, a_mag};
    for (int i = 0; i < NumDigits; i++) begin
      oct_digs[4*i +: 4] = {1'b0, mag_ext[3*i +: 3]};
    end
  end

  // Shift-and-add-3 step over the twenty decimal digits in the top of the store.
  logic [4*NumDec-1:0] bcd_adj;
  always_comb begin
    for (int i = 0; i < NumDec; i++) begin
      if (digs[DigW-4*NumDec+4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = digs[DigW-4*NumDec+4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = digs[DigW-4*NumDec+4*i +: 4];
      end
    end
  end

  // Length planning once the digit count is known.
  logic signed [8:0] ndig9, len_chk, pad9, total9, zeros9;
  logic              ovf;
  always_comb begin
    ndig9   = signed'({{(9-DcntW){1'b0}}, dcnt}) + (alt_zero ? 9'sd1 : 9'sd0);
    len_chk = 9'sd1 + ndig9 + prec;
    pad9    = (prec > ndig9) ? (prec - ndig9) : 9'sd0;
    total9  = ndig9 + pad9 + (hex_prefix ? 9'sd2 : 9'sd0) + (has_sign ? 9'sd1 : 9'sd0);
    zeros9  = pad9 + (alt_zero ? 9'sd1 : 9'sd0);
    ovf     = (len_chk > Limit9) || (total9 > Max9);
  end

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            mag        <= a_mag;
            is_empty   <= a_empty;
            has_sign   <= a_sign;
            sign_char  <= a_sign_char;
            hex_prefix <= a_hexalt;
            upper      <= (conv_n == CONV_HEXU);
            alt_zero   <= a_az;
            prec       <= a_prec;
            bitcnt     <= '0;
            if (a_empty) begin
              state <= F_PLAN;
            end else if (a_dec) begin
              digs  <= '0;
              dcnt  <= DcntW'(NumDec);
              state <= F_CONV;
            end else if (a_oct) begin
              digs  <= oct_digs;
              dcnt  <= DcntW'(NumDigits);
              state <= F_SCAN;
            end else begin
              digs  <= {a_mag, {(DigW-64){1'b0}}};
              dcnt  <= DcntW'(NumHex);
              state <= F_SCAN;
            end
          end
        end
        F_CONV: begin
          digs   <= {bcd_adj[4*NumDec-2:0], mag[63], {(DigW-4*NumDec){1'b0}}};
          mag    <= {mag[62:0], 1'b0};
          bitcnt <= bitcnt + 6'd1;
          if (bitcnt == 6'd63) begin
            state <= F_SCAN;
          end
        end
        F_SCAN: begin
          // Drop leading zero digits, keeping at least one.
          if ((dcnt > DcntW'(1)) && (digs[DigW-1 -: 4] == 4'd0)) begin
            digs <= {digs[DigW-5:0], 4'd0};
            dcnt <= dcnt - DcntW'(1);
          end else begin
            state <= F_PLAN;
          end
        end
        F_PLAN: begin
          if (is_empty) begin
            entry.kind <= KIND_EMPTY;
          end else if (ovf) begin
            entry.kind <= KIND_OVF;
          end else begin
            entry.kind <= KIND_TEXT;
          end
          entry.has_sign   <= has_sign;
          entry.sign_char  <= sign_char;
          entry.hex_prefix <= hex_prefix;
          entry.upper      <= upper;
          entry.zeros      <= zeros9[5:0];
          entry.digits     <= digs;
          entry.total      <= total9[5:0];
          state            <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/itf_queue.sv =====
module itf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  itf_pkg::plan_t wdata,
  output logic           full,
  input  logic           pop,
  output itf_pkg::plan_t rdata,
  output logic           nempty
);
  import itf_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  plan_t           mem [QDepth];
  logic [PtrW-1:0] wp;
  logic [PtrW-1:0] rp;
  logic [PtrW:0]   cnt;

  assign full   = (cnt == (PtrW+1)'(QDepth));
  assign nempty = (cnt != '0);
  assign rdata  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PtrW'(1);
      end
      if (pop) begin
        rp <= rp + PtrW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (PtrW+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (PtrW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/itf_back.sv =====
module itf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nempty,
  output logic           q_pop,
  input  itf_pkg::plan_t q_data,
  output logic           strobe,
  output logic [7:0]     character,
  output logic           last,
  output logic           empty_res,
  output logic           overflow
);
  import itf_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_FLAG = 7'b0000010,
    B_SIGN = 7'b0000100,
    B_PFX0 = 7'b0001000,
    B_PFXX = 7'b0010000,
    B_ZERO = 7'b0100000,
    B_DIG  = 7'b1000000
  } bstate_t;

  function automatic bstate_t body_phase(input logic [5:0] zeros);
    return (zeros != 6'd0) ? B_ZERO : B_DIG;
  endfunction

  function automatic bstate_t prefix_phase(input plan_t p);
    return p.hex_prefix ? B_PFX0 : body_phase(p.zeros);
  endfunction

  function automatic bstate_t first_phase(input plan_t p);
    if (p.kind != KIND_TEXT) begin
      return B_FLAG;
    end
    return p.has_sign ? B_SIGN : prefix_phase(p);
  endfunction

  bstate_t    state;
  plan_t      cur;
  logic [7:0] ch;
  logic       is_last;

  assign q_pop = (state == B_IDLE) && q_nempty;

  always_comb begin
    case (state)
      B_SIGN:  ch = cur.sign_char;
      B_PFX0:  ch = CH_ZERO;
      B_PFXX:  ch = cur.upper ? CH_UX : CH_LX;
      B_ZERO:  ch = CH_ZERO;
      B_DIG:   ch = digit_char(cur.digits[DigW-1 -: 4], cur.upper);
      default: ch = CH_NONE;
    endcase
    is_last = (state == B_FLAG) || (cur.total == 6'd1);
  end

  always_ff @(posedge clk) begin
    character <= ch;
    last      <= is_last;
    empty_res <= (state == B_FLAG) && (cur.kind == KIND_EMPTY);
    overflow  <= (state == B_FLAG) && (cur.kind == KIND_OVF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= (state != B_IDLE);
      case (state)
        B_IDLE: begin
          if (q_nempty) begin
            cur   <= q_data;
            state <= first_phase(q_data);
          end
        end
        B_FLAG: state <= B_IDLE;
        default: begin
          cur.total <= cur.total - 6'd1;
          if (state == B_ZERO) begin
            cur.zeros <= cur.zeros - 6'd1;
          end
          if (state == B_DIG) begin
            cur.digits <= {cur.digits[DigW-5:0], 4'd0};
          end
          if (is_last) begin
            state <= B_IDLE;
          end else begin
            case (state)
              B_SIGN:  state <= prefix_phase(cur);
              B_PFX0:  state <= B_PFXX;
              B_PFXX:  state <= body_phase(cur.zeros);
              B_ZERO:  state <= (cur.zeros == 6'd1) ? B_DIG : B_ZERO;
              default: state <= B_DIG;
            endcase
          end
        end
      endcase
    end
  end

endmodule
